@@ sv/b64d_pkg.sv @@
// b64d_pkg: types, constants and the character classifier of the base64 decoder
// no dependencies; used by the front, queue and back modules

package b64d_pkg;

    // character codes of the alphabet bounds and padding
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // sextet offsets and fixed values
    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    // position in a group of four
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    // class of one character
    typedef enum logic [1:0] {
        CLS_SEXTET,
        CLS_PAD,
        CLS_INVALID
    } t_class;

    // classified item as held in the queue
    typedef struct packed {
        t_class     cls;
        logic [5:0] sextet;
        logic       final_char;
    } t_entry;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       error;
        logic       end_of_string;
    } t_result;

    // map a character to its class and sextet
    function automatic t_entry classify(input logic [7:0] c, input logic f);
        t_entry     e;
        logic [7:0] d;
        e.cls        = CLS_INVALID;
        e.sextet     = '0;
        e.final_char = f;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d        = c - CHAR_UPPER_A;
            e.cls    = CLS_SEXTET;
            e.sextet = d[5:0];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d        = c - CHAR_LOWER_A;
            e.cls    = CLS_SEXTET;
            e.sextet = d[5:0] + SEXTET_LOWER_BASE;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            d        = c - CHAR_DIGIT_0;
            e.cls    = CLS_SEXTET;
            e.sextet = d[5:0] + SEXTET_DIGIT_BASE;
        end else if (c == CHAR_PLUS) begin
            e.cls    = CLS_SEXTET;
            e.sextet = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            e.cls    = CLS_SEXTET;
            e.sextet = SEXTET_SLASH;
        end else if (c == CHAR_PAD) begin
            e.cls    = CLS_PAD;
        end
        return e;
    endfunction

endpackage

@@ sv/b64d_in_if.sv @@
// b64d_in_if: character channel of the base64 decoder (valid/ready and payload)
// no dependencies

interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       final_char;

    modport source (output valid, output in_char, output final_char, input ready);
    modport sink   (input valid, input in_char, input final_char, output ready);
endinterface

@@ sv/b64d_out_if.sv @@
// b64d_out_if: result channel of the base64 decoder (valid/ready and payload)
// no dependencies

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       error;
    logic       end_of_string;

    modport source (output valid, output out_byte, output byte_valid, output error,
                    output end_of_string, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input error,
                    input end_of_string, output ready);
endinterface

@@ sv/b64d_front.sv @@
// b64d_front: accepts characters and classifies them into queue entries
// depends on b64d_pkg and b64d_in_if

module b64d_front (
    b64d_in_if.sink          i_in,
    input  logic             i_queue_full,
    output logic             o_push,
    output b64d_pkg::t_entry o_entry
);

    // accept whenever the queue has room
    assign i_in.ready = !i_queue_full;
    assign o_push     = i_in.valid && !i_queue_full;

    // alphabet lookup
    assign o_entry = b64d_pkg::classify(i_in.in_char, i_in.final_char);

endmodule

@@ sv/b64d_queue.sv @@
// b64d_queue: short queue of classified items between front and back
// depends on b64d_pkg

module b64d_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64d_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output b64d_pkg::t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // next pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

endmodule

@@ sv/b64d_back.sv @@
// b64d_back: group state, byte splicing and the registered result stage
// depends on b64d_pkg and b64d_out_if

module b64d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  b64d_pkg::t_entry i_head,
    output logic             o_pop,
    b64d_out_if.source       o_out
);

    logic [1:0]        r_phase, n_phase;
    logic [5:0]        r_prev, n_prev;
    logic              r_skip, n_skip;
    logic              r_err, n_err;
    logic              r_out_valid;
    b64d_pkg::t_result r_out;
    b64d_pkg::t_result res;
    logic              has_res;
    logic              out_free;

    assign out_free = !r_out_valid || o_out.ready;

    // decode the head item against the group state
    always_comb begin
        n_phase = r_phase;
        n_prev  = r_prev;
        n_skip  = r_skip;
        n_err   = r_err;
        res     = '0;
        has_res = i_head.final_char;
        res.end_of_string = i_head.final_char;
        if (r_err) begin
            res.error = 1'b1;
        end else if (r_phase == b64d_pkg::PHASE_3 && r_skip) begin
            n_phase = b64d_pkg::PHASE_0;
            n_skip  = 1'b0;
        end else if (i_head.cls == b64d_pkg::CLS_PAD && r_phase[1]) begin
            if (r_phase == b64d_pkg::PHASE_2) begin
                n_skip  = 1'b1;
                n_phase = b64d_pkg::PHASE_3;
            end else begin
                n_phase = b64d_pkg::PHASE_0;
            end
        end else if (i_head.cls != b64d_pkg::CLS_SEXTET) begin
            n_err     = 1'b1;
            has_res   = 1'b1;
            res.error = 1'b1;
        end else begin
            n_prev  = i_head.sextet;
            n_phase = r_phase + 1'b1;
            unique case (r_phase)
                b64d_pkg::PHASE_0: begin
                    res.error = 1'b1;
                end
                b64d_pkg::PHASE_1: begin
                    has_res        = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = {r_prev, i_head.sextet[5:4]};
                end
                b64d_pkg::PHASE_2: begin
                    has_res        = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = {r_prev[3:0], i_head.sextet[5:2]};
                end
                default: begin
                    has_res        = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = {r_prev[1:0], i_head.sextet};
                end
            endcase
        end
        // the final character always starts the next string from reset state
        if (i_head.final_char) begin
            n_phase = b64d_pkg::PHASE_0;
            n_prev  = '0;
            n_skip  = 1'b0;
            n_err   = 1'b0;
        end
    end

    // items without a result never wait for the output stage
    assign o_pop = i_head_valid && (!has_res || out_free);

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64d_pkg::PHASE_0;
            r_prev  <= '0;
            r_skip  <= 1'b0;
            r_err   <= 1'b0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_skip  <= n_skip;
            r_err   <= n_err;
        end
    end

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_pop && has_res;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_free && o_pop && has_res) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out.out_byte;
    assign o_out.byte_valid    = r_out.byte_valid;
    assign o_out.error         = r_out.error;
    assign o_out.end_of_string = r_out.end_of_string;

endmodule

@@ sv/base64_decoder_top.sv @@
// Streaming base64 decoder: one character item in, at most one result item out. The front
// classifies each character and places it in a small queue; the back keeps the group state and
// writes results into an output register. One character is accepted every cycle while the
// queue has room, so the sustained rate is one item per cycle; a result passes through the
// queue storage and then the output register before it is offered. The queue depth
// (QUEUE_DEPTH) sets how many characters are absorbed while the result side is held off.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_front, b64d_queue and b64d_back.

module base64_decoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64d_in_if.sink    i_in,
    b64d_out_if.source o_out
);

    b64d_pkg::t_entry entry;
    b64d_pkg::t_entry head;
    logic             push;
    logic             pop;
    logic             full;
    logic             head_valid;

    // accept and classify
    b64d_front u_front (
        .i_in         (i_in),
        .i_queue_full (full),
        .o_push       (push),
        .o_entry      (entry)
    );

    // decoupling queue
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // decode and deliver
    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

@@ sv/b64d_checker.sv @@
// b64d_port_checks: port-level assertions on the result channel of the decoder
// bound to base64_decoder_top; no other dependencies

module b64d_port_checks (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_error,
    input logic       i_end_of_string
);

    // a stalled item stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result item withdrawn while stalled");

    // a stalled item keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_out_byte) && $stable(i_byte_valid)
                               && $stable(i_error) && $stable(i_end_of_string))
        else $error("result payload changed while stalled");

    // a decoded byte never comes with an error
    a_byte_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_byte_valid && i_error))
        else $error("byte and error flagged together");

    // no byte means a zero byte field
    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_byte_valid |-> i_out_byte == 8'h00)
        else $error("out_byte nonzero without byte_valid");

    // a result without a byte is either an error or the end of the string
    a_empty_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_byte_valid |-> i_error || i_end_of_string)
        else $error("empty result with no cause");

endmodule

bind base64_decoder_top b64d_port_checks u_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_out.valid),
    .i_ready         (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_byte_valid    (o_out.byte_valid),
    .i_error         (o_out.error),
    .i_end_of_string (o_out.end_of_string)
);
